[hdl/assert_macros.svh]
// Assertion macros shared by the delta-list timer queue RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds in this cycle, so c holds in the same cycle
`define DLTQ_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// a holds in this cycle, so c holds in the next cycle
`define DLTQ_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

`endif

[hdl/dltq_pkg.sv]
// Package for the delta-list timer queue: sizes, op codes, FSM states and the
// command/status structs between controller and datapath. No dependencies.
package dltq_pkg;

  localparam int TIMERS = 16;
  localparam int ID_W   = $clog2(TIMERS);
  localparam int IDX_W  = ID_W + 1;
  localparam int TICK_W = 32;

  localparam logic [IDX_W-1:0] END_IDX = IDX_W'(TIMERS);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } dltq_op_t;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_INS_WALK  = 8'b0000_0010,
    S_INS_LINK  = 8'b0000_0100,
    S_DEL_WALK  = 8'b0000_1000,
    S_DEL_FIX   = 8'b0001_0000,
    S_TICK_DEC  = 8'b0010_0000,
    S_TICK_EMIT = 8'b0100_0000,
    S_TICK_CHK  = 8'b1000_0000
  } dltq_state_t;

  typedef struct packed {
    logic load;
    logic ins_step;
    logic ins_end;
    logic ins_link;
    logic del_step;
    logic del_hit;
    logic del_abort;
    logic del_fix;
    logic tick_dec;
    logic tick_emit;
    logic tick_chk;
  } dltq_cmd_t;

  typedef struct packed {
    logic head_empty;
    logic id_running;
    logic ins_more;
    logic del_hit;
    logic del_end;
    logic tick_zero;
    logic chain_more;
  } dltq_sts_t;

endpackage

[hdl/dltq_ctrl.sv]
// Controller FSM of the delta-list timer queue: sequences insert, unlink and
// tick walks. Depends on dltq_pkg; drives the datapath by command struct.
module dltq_ctrl
  import dltq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  op,
  input  dltq_sts_t   sts,
  output dltq_cmd_t   cmd,
  output logic        busy
);

  dltq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (dltq_op_t'(op))
            OP_TICK:  if (!sts.head_empty) state_next = S_TICK_DEC;
            OP_START: if (!sts.id_running) state_next = S_INS_WALK;
            OP_STOP:  if (sts.id_running)  state_next = S_DEL_WALK;
            OP_NONE:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_INS_WALK: begin
        if (sts.ins_more) begin
          cmd.ins_step = 1'b1;
        end else begin
          cmd.ins_end = 1'b1;
          state_next  = S_INS_LINK;
        end
      end
      S_INS_LINK: begin
        cmd.ins_link = 1'b1;
        state_next   = S_IDLE;
      end
      S_DEL_WALK: begin
        priority if (sts.del_end) begin
          cmd.del_abort = 1'b1;
          state_next    = S_IDLE;
        end else if (sts.del_hit) begin
          cmd.del_hit = 1'b1;
          state_next  = S_DEL_FIX;
        end else begin
          cmd.del_step = 1'b1;
        end
      end
      S_DEL_FIX: begin
        cmd.del_fix = 1'b1;
        state_next  = S_IDLE;
      end
      S_TICK_DEC: begin
        cmd.tick_dec = 1'b1;
        state_next   = sts.tick_zero ? S_TICK_EMIT : S_IDLE;
      end
      S_TICK_EMIT: begin
        cmd.tick_emit = 1'b1;
        state_next    = S_TICK_CHK;
      end
      S_TICK_CHK: begin
        cmd.tick_chk = 1'b1;
        state_next   = sts.chain_more ? S_TICK_EMIT : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/dltq_datapath.sv]
// Datapath of the delta-list timer queue: delta and link tables, walk
// registers and the result register. Depends on dltq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dltq_datapath
  import dltq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dltq_cmd_t         cmd,
  input  logic [ID_W-1:0]   timer_id,
  input  logic [TICK_W-1:0] period,
  output dltq_sts_t         sts,
  output logic              valid,
  output logic [ID_W-1:0]   expired_id,
  output logic              last
);

  logic [TICK_W-1:0] delta_mem [TIMERS];
  logic [IDX_W-1:0]  next_mem  [TIMERS];
  logic [TIMERS-1:0] running;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  prev;
  logic [TICK_W-1:0] rem;
  logic [ID_W-1:0]   id;

  logic [TICK_W-1:0] rd_delta;
  logic [IDX_W-1:0]  rd_next;
  logic [TICK_W-1:0] dec;
  logic              cur_valid;

  logic              d_we;
  logic [ID_W-1:0]   d_addr;
  logic [TICK_W-1:0] d_wdata;
  logic              n_we;
  logic [ID_W-1:0]   n_addr;
  logic [IDX_W-1:0]  n_wdata;

  assign cur_valid = !cur[IDX_W-1];
  assign rd_delta  = delta_mem[cur[ID_W-1:0]];
  assign rd_next   = next_mem[cur[ID_W-1:0]];
  assign dec       = (rd_delta == '0) ? '0 : rd_delta - TICK_W'(1);

  always_comb begin
    sts.head_empty = head[IDX_W-1];
    sts.id_running = running[timer_id];
    sts.ins_more   = cur_valid && (rd_delta <= rem);
    sts.del_end    = !cur_valid;
    sts.del_hit    = cur_valid && (cur[ID_W-1:0] == id);
    sts.tick_zero  = (dec == '0);
    sts.chain_more = cur_valid && (rd_delta == '0);
  end

  // table write selection, one address per table per cycle
  always_comb begin
    d_we    = 1'b0;
    d_addr  = cur[ID_W-1:0];
    d_wdata = dec;
    priority if (cmd.ins_end) begin
      d_we    = cur_valid;
      d_wdata = rd_delta - rem;
    end else if (cmd.ins_link) begin
      d_we    = 1'b1;
      d_addr  = id;
      d_wdata = rem;
    end else if (cmd.del_fix) begin
      d_we    = cur_valid;
      d_wdata = rd_delta + rem;
    end else if (cmd.tick_dec) begin
      d_we    = 1'b1;
    end
  end

  always_comb begin
    n_we    = 1'b0;
    n_addr  = cur[ID_W-1:0];
    n_wdata = END_IDX;
    priority if (cmd.ins_end) begin
      n_we    = 1'b1;
      n_addr  = id;
      n_wdata = cur;
    end else if (cmd.ins_link) begin
      n_we    = !prev[IDX_W-1];
      n_addr  = prev[ID_W-1:0];
      n_wdata = {1'b0, id};
    end else if (cmd.del_hit) begin
      n_we    = !prev[IDX_W-1];
      n_addr  = prev[ID_W-1:0];
      n_wdata = rd_next;
    end else if (cmd.del_fix) begin
      n_we    = 1'b1;
      n_addr  = id;
    end else if (cmd.tick_emit) begin
      n_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      delta_mem[d_addr] <= d_wdata;
    end
    if (n_we) begin
      next_mem[n_addr] <= n_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      head    <= END_IDX;
      valid   <= 1'b0;
    end else begin
      valid <= cmd.tick_chk;
      if (cmd.ins_link) begin
        running[id] <= 1'b1;
        if (prev[IDX_W-1]) head <= {1'b0, id};
      end
      if (cmd.del_hit || cmd.del_abort) begin
        running[id] <= 1'b0;
      end
      if (cmd.del_hit && prev[IDX_W-1]) begin
        head <= rd_next;
      end
      if (cmd.tick_emit) begin
        running[cur[ID_W-1:0]] <= 1'b0;
      end
      if (cmd.tick_chk && !sts.chain_more) begin
        head <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id   <= timer_id;
      cur  <= head;
      prev <= END_IDX;
      rem  <= (period == '0) ? TICK_W'(1) : period;
    end
    if (cmd.ins_step) begin
      rem  <= rem - rd_delta;
      prev <= cur;
      cur  <= rd_next;
    end
    if (cmd.del_step) begin
      prev <= cur;
      cur  <= rd_next;
    end
    if (cmd.del_hit) begin
      rem <= rd_delta;
      cur <= rd_next;
    end
    if (cmd.tick_emit) begin
      prev <= cur;
      cur  <= rd_next;
    end
    if (cmd.tick_chk) begin
      expired_id <= prev[ID_W-1:0];
      last       <= !sts.chain_more;
    end
  end

  `DLTQ_ASSERT_NXT(a_strobe_gap, clk, rst, valid, !valid, "result strobes back to back")
  `DLTQ_ASSERT_IMP(a_emit_linked, clk, rst, cmd.tick_emit,
                   cur_valid && running[cur[ID_W-1:0]], "expiring entry not linked")
  `DLTQ_ASSERT_NXT(a_link_sets, clk, rst, cmd.ins_link, running[$past(id)] && !head[IDX_W-1],
                   "inserted timer not running")

endmodule

[hdl/delta_list_timer_queue_unit.sv]
// Top level of the delta-list timer queue: joins controller and datapath.
// Depends on dltq_pkg, dltq_ctrl and dltq_datapath.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------
//   request  | start / busy       | op, timer_id, period
//   expiry   | valid (strobe)     | expired_id, last
//
// An item is taken when start is high and busy low. A tick decrements the head
// entry, then emits and checks each expired timer in turn; a start or stop walks
// the list one entry a cycle. Each expiry shows for one cycle on valid; the receiver
// cannot stall. Synchronous reset empties the list; the tables need no sweep.
module delta_list_timer_queue_unit
  import dltq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op,
  input  logic [ID_W-1:0]   timer_id,
  input  logic [TICK_W-1:0] period,
  output logic              valid,
  output logic [ID_W-1:0]   expired_id,
  output logic              last
);

  dltq_cmd_t cmd;
  dltq_sts_t sts;

  dltq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dltq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .timer_id   (timer_id),
    .period     (period),
    .sts        (sts),
    .valid      (valid),
    .expired_id (expired_id),
    .last       (last)
  );

endmodule

[tb/sv/dltq_checker.sv]
// Checker for the delta-list timer queue: keeps its own copy of the timer list,
// predicts the expiries of each accepted item and compares them in order.
// Depends on dltq_pkg.
module dltq_checker
  import dltq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        op,
  input  logic [ID_W-1:0]   timer_id,
  input  logic [TICK_W-1:0] period,
  input  logic              valid,
  input  logic [ID_W-1:0]   expired_id,
  input  logic              last,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } expiry_t;

  logic [TICK_W-1:0] rel_ticks [TIMERS];
  logic [IDX_W-1:0]  next_idx [TIMERS];
  logic              armed [TIMERS];
  logic [IDX_W-1:0]  head_idx;
  expiry_t           due_expiries [$];
  int                errors;
  int                shown;

  task automatic clear_list();
    for (int i = 0; i < TIMERS; i++) begin
      rel_ticks[i] = '0;
      next_idx[i]  = END_IDX;
      armed[i]     = 1'b0;
    end
    head_idx = END_IDX;
  endtask

  task automatic arm_timer(input logic [ID_W-1:0] id, input logic [TICK_W-1:0] ticks);
    logic [TICK_W-1:0] remain;
    logic [IDX_W-1:0]  prev;
    logic [IDX_W-1:0]  cur;
    int                steps;
    remain = (ticks == '0) ? TICK_W'(1) : ticks;
    prev   = END_IDX;
    cur    = head_idx;
    steps  = 0;
    if (armed[id]) return;
    while (cur < END_IDX && steps < TIMERS && rel_ticks[cur[ID_W-1:0]] <= remain) begin
      remain = remain - rel_ticks[cur[ID_W-1:0]];
      prev   = cur;
      cur    = next_idx[cur[ID_W-1:0]];
      steps++;
    end
    if (cur < END_IDX) rel_ticks[cur[ID_W-1:0]] = rel_ticks[cur[ID_W-1:0]] - remain;
    else cur = END_IDX;
    rel_ticks[id] = remain;
    next_idx[id]  = cur;
    if (prev < END_IDX) next_idx[prev[ID_W-1:0]] = IDX_W'(id);
    else head_idx = IDX_W'(id);
    armed[id] = 1'b1;
  endtask

  task automatic disarm_timer(input logic [ID_W-1:0] id);
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] succ;
    int               steps;
    prev  = END_IDX;
    cur   = head_idx;
    steps = 0;
    if (!armed[id]) return;
    while (cur < END_IDX && cur != IDX_W'(id) && steps < TIMERS) begin
      prev = cur;
      cur  = next_idx[cur[ID_W-1:0]];
      steps++;
    end
    armed[id] = 1'b0;
    if (cur != IDX_W'(id)) return;
    succ = next_idx[id];
    if (succ >= END_IDX) succ = END_IDX;
    if (prev < END_IDX) next_idx[prev[ID_W-1:0]] = succ;
    else head_idx = succ;
    if (succ < END_IDX)
      rel_ticks[succ[ID_W-1:0]] = rel_ticks[succ[ID_W-1:0]] + rel_ticks[id];
    next_idx[id] = END_IDX;
  endtask

  task automatic advance_tick();
    logic [IDX_W-1:0] h;
    logic [IDX_W-1:0] nx;
    expiry_t          ex;
    int               n;
    h = head_idx;
    n = 0;
    if (h >= END_IDX) return;
    if (rel_ticks[h[ID_W-1:0]] != '0) rel_ticks[h[ID_W-1:0]] = rel_ticks[h[ID_W-1:0]] - 1;
    if (rel_ticks[h[ID_W-1:0]] != '0) return;
    while (h < END_IDX && rel_ticks[h[ID_W-1:0]] == '0 && n < TIMERS) begin
      nx = next_idx[h[ID_W-1:0]];
      armed[h[ID_W-1:0]]    = 1'b0;
      next_idx[h[ID_W-1:0]] = END_IDX;
      ex.id   = h[ID_W-1:0];
      ex.last = !(nx < END_IDX && rel_ticks[nx[ID_W-1:0]] == '0 && n + 1 < TIMERS);
      due_expiries.push_back(ex);
      n++;
      h = (nx < END_IDX) ? nx : END_IDX;
    end
    head_idx = h;
  endtask

  always @(posedge clk) begin
    expiry_t ex;
    if (rst) begin
      clear_list();
      due_expiries.delete();
      errors = 0;
      shown  = 0;
    end else begin
      if (valid) begin
        if (due_expiries.size() == 0) begin
          errors++;
          if (shown < 10) begin
            $display("unexpected expiry: id %0d last %0b", expired_id, last);
            shown++;
          end
        end else begin
          ex = due_expiries.pop_front();
          if (expired_id !== ex.id || last !== ex.last) begin
            errors++;
            if (shown < 10) begin
              $display("expiry mismatch: expected id %0d last %0b, got id %0d last %0b",
                       ex.id, ex.last, expired_id, last);
              shown++;
            end
          end
        end
      end
      if (start && !busy) begin
        case (dltq_op_t'(op))
          OP_TICK:  advance_tick();
          OP_START: arm_timer(timer_id, period);
          OP_STOP:  disarm_timer(timer_id);
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending    <= due_expiries.size();
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for delta_list_timer_queue_unit: drives bursts of tick, start
// and stop items and gives the verdict. Depends on dltq_pkg and dltq_checker.
module tb;
  import dltq_pkg::*;

  localparam int ITEMS      = 370;
  localparam int IDLE_LIMIT = 1000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        op;
  logic [ID_W-1:0]   timer_id;
  logic [TICK_W-1:0] period;
  logic              valid;
  logic [ID_W-1:0]   expired_id;
  logic              last;
  int                fail_count;
  int                pending;
  int                burst_left;
  int                items_sent;
  int                idle_cycles;

  delta_list_timer_queue_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .timer_id(timer_id),
    .period(period), .valid(valid), .expired_id(expired_id), .last(last)
  );

  dltq_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .timer_id(timer_id),
    .period(period), .valid(valid), .expired_id(expired_id), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input dltq_op_t o, input logic [ID_W-1:0] id,
                           input logic [TICK_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start    <= 1'b1;
    op       <= o;
    timer_id <= id;
    period   <= p;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  function automatic logic [TICK_W-1:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return '0;
      2:       return ~TICK_W'($urandom_range(0, 3));
      default: return TICK_W'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    int kind;
    int p;
    rst         <= 1'b1;
    start       <= 1'b0;
    op          <= OP_TICK;
    timer_id    <= '0;
    period      <= '0;
    burst_left  = 0;
    items_sent  = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_item(OP_TICK, 4'd0, 32'd0);            // empty list
    send_item(OP_STOP, 4'd5, 32'd0);            // idle timer
    send_item(OP_NONE, 4'd15, 32'hFFFF_FFFF);   // unused op
    send_item(OP_START, 4'd0, 32'd0);           // zero period
    send_item(OP_START, 4'd0, 32'd7);           // already running
    send_item(OP_START, 4'd15, 32'hFFFF_FFFF);
    send_item(OP_START, 4'd3, 32'd1);           // equal expiry
    send_item(OP_START, 4'd9, 32'd1);
    send_item(OP_START, 4'd4, 32'd5);
    send_item(OP_START, 4'd6, 32'd5);
    send_item(OP_START, 4'd7, 32'd3);
    send_item(OP_STOP, 4'd7, 32'd0);            // middle of list
    send_item(OP_STOP, 4'd9, 32'd0);            // inside a zero chain
    send_item(OP_TICK, 4'd0, 32'd0);
    send_item(OP_STOP, 4'd15, 32'd0);           // tail
    send_item(OP_STOP, 4'd4, 32'd0);            // head
    send_item(OP_START, 4'd1, 32'd1);           // new head
    send_item(OP_TICK, 4'd0, 32'd0);
    send_item(OP_TICK, 4'd15, 32'hFFFF_FFFF);
    send_item(OP_STOP, 4'd6, 32'd0);
    drain();

    while (items_sent < ITEMS) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        repeat ($urandom_range(1, 6))
          send_item(OP_START, ID_W'($urandom_range(0, 15)), pick_period());
        if ($urandom_range(0, 2) == 0)
          send_item(OP_STOP, ID_W'($urandom_range(0, 15)), $urandom());
        repeat ($urandom_range(1, 8))
          send_item(OP_TICK, ID_W'($urandom_range(0, 15)), $urandom());
      end else if (kind < 14) begin
        // clear, arm all timers alike, tick them out together
        for (int i = 0; i < TIMERS; i++) send_item(OP_STOP, ID_W'(i), $urandom());
        p = $urandom_range(0, 3);
        for (int i = 0; i < TIMERS; i++) send_item(OP_START, ID_W'(i), p);
        repeat ((p == 0) ? 1 : p)
          send_item(OP_TICK, ID_W'($urandom_range(0, 15)), $urandom());
      end else if (kind < 15) begin
        drain();
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(dltq_op_t'(2'($urandom_range(0, 3))), ID_W'($urandom_range(0, 15)),
                    $urandom());
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
